FILE: src/tsaf_pkg.sv
// Shared constants, types and state codes for the timer slack adaptive filter.
package tsaf_pkg;

	localparam int RING_DEPTH = 32;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int MIN_TAPS   = 4;

	localparam int PERIOD_W = 32;
	localparam int SLACK_W  = 32;
	localparam int LIMIT_W  = 24;
	localparam int SPAN_W   = 16;
	localparam int ADJ_W    = 25;
	localparam int TAPS_W   = 6;

	// ring sum of up to RING_DEPTH samples, then times three
	localparam int SUM_W  = ADJ_W + RING_AW;
	localparam int SUM3_W = SUM_W + 2;
	localparam int DVD_W  = SUM_W + 1;
	localparam int DVS_W  = PERIOD_W;
	localparam int STEP_W = $clog2(DVD_W + 1);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SLACK_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_SPAN = CFG_IDX_W'(1);

	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(100000);
	localparam logic [SPAN_W-1:0]  SPAN_RST  = SPAN_W'(1000);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV1 = 6'b000010,
		ST_SUM  = 6'b000100,
		ST_MUL3 = 6'b001000,
		ST_DIV2 = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: src/tsaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/tsaf_div.sv
// Shared restoring divider, one quotient bit per cycle.
module tsaf_div
	import tsaf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quot_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;
	logic             qbit;
	logic [DVS_W-1:0] rem_nxt;

	// shift in the next dividend bit, subtract if it fits
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign diff    = {1'b0, trial} - {2'b0, dvs_q};
	assign qbit    = ~diff[DVS_W+1];
	assign rem_nxt = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dvs_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q  <= rem_nxt;
			quot_q <= {quot_q[DVD_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: src/timer_slack_adaptive_filter.sv
// Top level: slack ring, adaptive tap count and scaled moving average.
//
//  channel  | signals                         | word
//  ---------+---------------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | period_ms, slack_us; tuser req_type
//  output   | m_tvalid m_tready m_tdata       | adjust_us, taps_used, warmed_up
//  config   | cfg_valid cfg_ready cfg_index cfg_data | 0 slack_limit_us, 1 filter_span_ms
//
// One word at a time. A wake word or an update before the ring is full goes straight to the
// final state. A warmed-up update is accepted, then runs the tap division, the ring read-back
// of taps samples (one ring read port), the x3 and the final division, and then loads the
// output, with both divisions on the one shared divider. s_tready stays low until the result
// is in the output register; a stalled output holds the next result in its final state.
// Reset clears control state and loads the configuration defaults; the datapath registers
// and the ring contents stay undefined until written.
module timer_slack_adaptive_filter
	import tsaf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // period_ms[31:0], slack_us[63:32]
	input  logic [0:0]            s_tuser,   // req_type[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // adjust_us[24:0], taps_used[30:25], warmed_up[31]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q;

	logic [LIMIT_W-1:0]  limit_q;
	logic [SPAN_W-1:0]   span_q;
	logic [RING_AW-1:0]  slot_q;
	logic [FILL_W-1:0]   fill_q;
	logic [PERIOD_W-1:0] shortest_q;
	logic [ADJ_W-1:0]    adj_q;
	logic [FILL_W-1:0]   taps_res_q;
	logic                start_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;
	logic [FILL_W-1:0]   issue_cnt_q;
	logic                rd_vld_s1;

	logic [FILL_W-1:0]   taps_q;
	logic [RING_AW-1:0]  rd_ptr_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM3_W-1:0]   sum3_q;

	logic                accept;
	logic                wake;
	logic [PERIOD_W-1:0] period;
	logic signed [SLACK_W:0] slack_x;
	logic signed [SLACK_W:0] lim_x;
	logic signed [SLACK_W:0] nlim_x;
	logic signed [SLACK_W:0] clamped;
	logic [RING_AW-1:0]  slot_inc;
	logic [RING_AW-1:0]  slot_dec;
	logic [RING_AW-1:0]  ptr_dec;
	logic [FILL_W-1:0]   fill_nxt;
	logic                warm_nxt;
	logic [PERIOD_W-1:0] shortest_nxt;
	logic [FILL_W-1:0]   taps_clamp;
	logic [SUM3_W-1:0]   sum3_abs;
	logic                adj_neg;
	logic [ADJ_W-1:0]    adj_sat;
	logic                out_free;
	logic                out_load;
	logic [ADJ_W-1:0]    rdata;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign wake      = s_tuser[0];
	assign period    = s_tdata[PERIOD_W-1:0];

	// clamp slack to +/- limit
	assign slack_x = $signed({s_tdata[63], s_tdata[63:32]});
	assign lim_x   = $signed({{(SLACK_W+1-LIMIT_W){1'b0}}, limit_q});
	assign nlim_x  = -lim_x;
	always_comb begin
		priority if (slack_x > lim_x) begin
			clamped = lim_x;
		end else if (slack_x < nlim_x) begin
			clamped = nlim_x;
		end else begin
			clamped = slack_x;
		end
	end

	assign slot_inc = (slot_q == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign slot_dec = (slot_q == '0) ? RING_AW'(RING_DEPTH - 1) : slot_q - 1'b1;
	assign ptr_dec  = (rd_ptr_q == '0) ? RING_AW'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
	assign fill_nxt = (fill_q == FILL_W'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign warm_nxt = (fill_nxt == FILL_W'(RING_DEPTH));

	always_comb begin
		priority if (shortest_q == '0) begin
			shortest_nxt = (period != '0) ? period : PERIOD_W'(1);
		end else if (period != '0 && period < shortest_q) begin
			shortest_nxt = period;
		end else begin
			shortest_nxt = shortest_q;
		end
	end

	always_comb begin
		priority if (div_rsp.quot > DVD_W'(RING_DEPTH)) begin
			taps_clamp = FILL_W'(RING_DEPTH);
		end else if (div_rsp.quot < DVD_W'(MIN_TAPS)) begin
			taps_clamp = FILL_W'(MIN_TAPS);
		end else begin
			taps_clamp = div_rsp.quot[FILL_W-1:0];
		end
	end

	// sign and magnitude for the final division, saturate on the way back
	assign sum3_abs = sum3_q[SUM3_W-1] ? -sum3_q : sum3_q;
	assign adj_neg  = sum3_q[SUM3_W-1];
	always_comb begin
		priority if (!adj_neg && div_rsp.quot > DVD_W'((1 << (ADJ_W - 1)) - 1)) begin
			adj_sat = {1'b0, {(ADJ_W-1){1'b1}}};
		end else if (adj_neg && div_rsp.quot > DVD_W'(1 << (ADJ_W - 1))) begin
			adj_sat = {1'b1, {(ADJ_W-1){1'b0}}};
		end else if (adj_neg) begin
			adj_sat = -div_rsp.quot[ADJ_W-1:0];
		end else begin
			adj_sat = div_rsp.quot[ADJ_W-1:0];
		end
	end

	always_comb begin
		div_req.start = start_q;
		if (state_q == ST_DIV1) begin
			div_req.steps    = STEP_W'(SPAN_W);
			div_req.dividend = {span_q, {(DVD_W-SPAN_W){1'b0}}};
			div_req.divisor  = shortest_q;
		end else begin
			div_req.steps    = STEP_W'(DVD_W);
			div_req.dividend = sum3_abs[DVD_W-1:0];
			div_req.divisor  = {{(DVS_W-FILL_W-1){1'b0}}, taps_q, 1'b0};
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RST;
			span_q      <= SPAN_RST;
			slot_q      <= '0;
			fill_q      <= '0;
			shortest_q  <= '0;
			adj_q       <= '0;
			taps_res_q  <= '0;
			start_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			start_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SLACK_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
					REG_FILTER_SPAN: span_q  <= cfg_data[SPAN_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (wake) begin
							adj_q      <= '0;
							fill_q     <= '0;
							slot_q     <= '0;
							taps_res_q <= '0;
							state_q    <= ST_FIN;
						end else begin
							slot_q <= slot_inc;
							fill_q <= fill_nxt;
							if (warm_nxt) begin
								shortest_q <= shortest_nxt;
								start_q    <= 1'b1;
								state_q    <= ST_DIV1;
							end else begin
								taps_res_q <= '0;
								state_q    <= ST_FIN;
							end
						end
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						issue_cnt_q <= taps_clamp;
						state_q     <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (issue_cnt_q != '0) begin
						issue_cnt_q <= issue_cnt_q - 1'b1;
						rd_vld_s1   <= 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_MUL3;
					end
				end
				ST_MUL3: begin
					start_q <= 1'b1;
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						adj_q      <= adj_sat;
						taps_res_q <= taps_q;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV1 && div_rsp.done) begin
			taps_q   <= taps_clamp;
			rd_ptr_q <= slot_dec;
			sum_q    <= '0;
		end
		if (state_q == ST_SUM) begin
			if (issue_cnt_q != '0) begin
				rd_ptr_q <= ptr_dec;
			end
			if (rd_vld_s1) begin
				sum_q <= sum_q + {{(SUM_W-ADJ_W){rdata[ADJ_W-1]}}, rdata};
			end
		end
		if (state_q == ST_MUL3) begin
			sum3_q <= {{2{sum_q[SUM_W-1]}}, sum_q} + {sum_q[SUM_W-1], sum_q, 1'b0};
		end
		if (out_load) begin
			m_tdata_q <= {(fill_q == FILL_W'(RING_DEPTH)), TAPS_W'(taps_res_q), adj_q};
		end
	end

	tsaf_ram #(
		.WIDTH(ADJ_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (accept && !wake),
		.waddr(slot_q),
		.wdata(clamped[ADJ_W-1:0]),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	tsaf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the timer slack adaptive filter.
`timescale 1ns / 100ps

module tb;
	import tsaf_pkg::*;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_WAKE   = 1'b1;

	localparam longint ADJ_HI = (64'sd1 <<< (ADJ_W - 1)) - 1;
	localparam longint ADJ_LO = -(64'sd1 <<< (ADJ_W - 1));

	// same layout as m_tdata
	typedef struct packed {
		logic                    warm;
		logic [TAPS_W-1:0]       taps;
		logic signed [ADJ_W-1:0] adj;
	} filt_word_t;

	typedef enum int {LEAN_NONE, LEAN_UP, LEAN_DOWN} lean_t;

	class slack_filter_sb;
		logic signed [ADJ_W-1:0] ring [RING_DEPTH];
		int unsigned             slot;
		int unsigned             fill;
		logic [PERIOD_W-1:0]     shortest;
		logic signed [ADJ_W-1:0] adjust;
		logic [LIMIT_W-1:0]      limit;
		logic [SPAN_W-1:0]       span;
		filt_word_t              expq [$];
		int                      errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			slot     = 0;
			fill     = 0;
			shortest = '0;
			adjust   = '0;
			limit    = LIMIT_RST;
			span     = SPAN_RST;
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SLACK_LIMIT: limit = data[LIMIT_W-1:0];
				REG_FILTER_SPAN: span = data[SPAN_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expq.size();
		endfunction

		// advance the filter state by one accepted word and queue the expected result
		function void note_input(logic wake, logic [PERIOD_W-1:0] period,
				logic signed [SLACK_W-1:0] slack);
			longint      s;
			longint      lim;
			longint      sum;
			longint      adj;
			int unsigned taps;
			int unsigned pos;
			filt_word_t  w;
			taps = 0;
			if (wake) begin
				adjust = '0;
				fill   = 0;
				slot   = 0;
			end else begin
				s   = slack;
				lim = limit;
				if (s > lim) s = lim;
				else if (s < -lim) s = -lim;
				ring[slot] = s[ADJ_W-1:0];
				slot = (slot + 1) % RING_DEPTH;
				if (fill < RING_DEPTH) fill++;
				if (fill == RING_DEPTH) begin
					if (shortest == 0) shortest = (period != 0) ? period : 1;
					else if (period != 0 && period < shortest) shortest = period;
					taps = span / shortest;
					if (taps > RING_DEPTH) taps = RING_DEPTH;
					else if (taps < MIN_TAPS) taps = MIN_TAPS;
					sum = 0;
					pos = slot;
					repeat (taps) begin
						pos = (pos + RING_DEPTH - 1) % RING_DEPTH;
						sum += ring[pos];
					end
					adj = (sum * 3) / longint'(2 * taps);
					if (adj > ADJ_HI) adj = ADJ_HI;
					else if (adj < ADJ_LO) adj = ADJ_LO;
					adjust = adj[ADJ_W-1:0];
				end
			end
			w.adj  = adjust;
			w.taps = taps[TAPS_W-1:0];
			w.warm = (fill == RING_DEPTH);
			expq.push_back(w);
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check(logic [31:0] word);
			filt_word_t got;
			filt_word_t want;
			got = word;
			if (expq.size() == 0) begin
				report($sformatf("result word %h with nothing pending", word));
				return;
			end
			want = expq.pop_front();
			if (got.adj !== want.adj)
				report($sformatf("adjust_us %0d, want %0d", got.adj, want.adj));
			if (got.taps !== want.taps)
				report($sformatf("taps_used %0d, want %0d", got.taps, want.taps));
			if (got.warm !== want.warm)
				report($sformatf("warmed_up %b, want %b", got.warm, want.warm));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata   = '0;
	logic [0:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	slack_filter_sb sb = new();
	bit             calm = 1'b0;
	int             stall_left = 0;

	timer_slack_adaptive_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// output backpressure in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_word(logic wake, logic [PERIOD_W-1:0] period,
			logic [SLACK_W-1:0] slack);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= wake ? REQ_WAKE : REQ_UPDATE;
		s_tdata  <= {slack, period};
		do @(posedge clk); while (!s_tready);
		sb.note_input(wake, period, slack);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// span goes in with junk above its 16 bits; an unmapped index is written too
	task automatic set_regs(logic [LIMIT_W-1:0] limit, logic [SPAN_W-1:0] span);
		// the last word was taken; keep it from being taken again while idle
		s_tvalid <= 1'b0;
		wait_idle();
		cfg_write(REG_SLACK_LIMIT, CFG_DATA_W'(limit));
		cfg_write(REG_FILTER_SPAN, {8'($urandom), span});
		cfg_write(CFG_IDX_W'($urandom_range(2, 2 ** CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			2: return '1;
			default: return $urandom_range(1, 500);
		endcase
	endfunction

	function automatic logic [SLACK_W-1:0] pick_slack(lean_t lean, longint lim);
		longint v;
		longint mag;
		case ($urandom_range(0, 9))
			0: v = int'($urandom);
			1: v = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
			2: v = ($urandom_range(0, 1) ? lim : -lim) + int'($urandom_range(0, 2)) - 1;
			3: v = int'($urandom_range(0, 200)) - 100;
			default: begin
				mag = lim / 2 + longint'($urandom_range(0, 32'(lim)));
				case (lean)
					LEAN_UP:   v = mag;
					LEAN_DOWN: v = -mag;
					default:   v = longint'($urandom_range(0, 32'(2 * lim + 2))) - lim - 1;
				endcase
			end
		endcase
		return v[SLACK_W-1:0];
	endfunction

	task automatic run_phase(logic [LIMIT_W-1:0] limit, logic [SPAN_W-1:0] span,
			lean_t lean, int n, int wake_permille);
		set_regs(limit, span);
		repeat (n) begin
			if ($urandom_range(0, 999) < wake_permille)
				send_word(REQ_WAKE, $urandom, $urandom);
			else
				send_word(REQ_UPDATE, pick_period(), pick_slack(lean, limit));
		end
	endtask

	initial begin
		logic [SLACK_W-1:0] corner_slack [10];
		corner_slack = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd100000, 32'd100001,
			-32'sd100000, -32'sd100001, -32'sd1, 32'd1, 32'd99999};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wake while still empty, then fill all but one ring slot under the reset clamp;
		// nonzero periods here must not touch the minimum
		send_word(REQ_WAKE, '1, 32'h8000_0000);
		for (int i = 0; i < RING_DEPTH - 1; i++)
			send_word(REQ_UPDATE, (i % 2) ? 32'hFFFF_FFFF : 32'd7,
				(i < 10) ? corner_slack[i] : pick_slack(LEAN_NONE, 100000));
		set_regs(100000, 20);
		// first warmed word with zero period sets the minimum to one
		send_word(REQ_UPDATE, 32'd0, 32'h7FFF_FFFF);
		send_word(REQ_UPDATE, 32'd0, -32'sd5);
		send_word(REQ_UPDATE, 32'd5, 32'd12345);
		send_word(REQ_WAKE, 32'd0, 32'd0);
		send_word(REQ_UPDATE, 32'd3, 32'd10);

		run_phase(0, 4, LEAN_NONE, 45, 10);
		run_phase(10000000, 1000, LEAN_NONE, 50, 10);
		// clamp at the top of the adjustment range drives saturation both ways
		run_phase(24'hFF_FFFF, 32, LEAN_UP, 50, 5);
		calm = 1'b1;
		run_phase(24'hFF_FFFF, 33, LEAN_DOWN, 50, 5);
		calm = 1'b0;
		run_phase(1, 16'hFFFF, LEAN_NONE, 45, 10);
		run_phase(5000, 0, LEAN_NONE, 45, 30);
		run_phase(100000, 3, LEAN_NONE, 45, 10);
		run_phase(10000000, 17, LEAN_UP, 45, 10);
		run_phase(777, 31, LEAN_DOWN, 45, 10);
		run_phase(LIMIT_W'($urandom_range(0, 10000000)), SPAN_W'($urandom_range(1, 40)),
			LEAN_NONE, 45, 40);
		calm = 1'b1;
		run_phase(LIMIT_W'($urandom_range(0, 10000000)), SPAN_W'($urandom_range(1, 40)),
			LEAN_NONE, 50, 10);
		s_tvalid <= 1'b0;

		wait_idle();
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: timer_slack_adaptive_filter.f
src/tsaf_pkg.sv
src/tsaf_ram.sv
src/tsaf_div.sv
src/timer_slack_adaptive_filter.sv
test/tb.sv
